>>> rtl/jtw_pkg.sv
// Shared types, constants and lookup functions for the joystick to wheel speeds mixer.
package jtw_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_SCALE = 40;        // axes are left-aligned to this many bits
  localparam int XW           = 43;        // CORDIC x/y width, signed
  localparam int ZW           = 25;        // CORDIC angle width, signed, 2^-16 deg
  localparam int Z_FRAC       = 16;
  localparam int ZMAX         = 90 * (2 ** Z_FRAC);
  localparam int NUM_BANDS    = 13;
  localparam int BAND_W       = 10;        // band edges in half degrees
  localparam int MAG_W        = 4;
  localparam int SPEED_W      = 6;
  localparam int CODE_W       = 4;
  localparam int OUT_TDATA_W  = 2 * SPEED_W + CODE_W;

  typedef enum logic [CODE_W-1:0] {
    MOT_SPIN_LEFT   = 4'd0,
    MOT_FWD_PIVOT_R = 4'd1,
    MOT_FWD_RIGHT   = 4'd2,
    MOT_FWD         = 4'd3,
    MOT_FWD_LEFT    = 4'd4,
    MOT_FWD_PIVOT_L = 4'd5,
    MOT_SPIN_RIGHT  = 4'd6,
    MOT_REV_PIVOT_R = 4'd7,
    MOT_REV_RIGHT   = 4'd8,
    MOT_REV         = 4'd9,
    MOT_REV_LEFT    = 4'd10,
    MOT_REV_PIVOT_L = 4'd11
  } motion_t;

  // Sideband that rides along the CORDIC stages.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             fwd_neg;
    logic             side_neg;
    logic             side_zero;
    logic             fwd_zero;
  } side_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Band edges (half degrees) and codes, in test order
  function automatic logic [BAND_W-1:0] band_lo(input logic [3:0] idx);
    logic [BAND_W-1:0] v;
    unique case (idx)
      4'd0:    v = 10'd135;
      4'd1:    v = 10'd55;
      4'd2:    v = 10'd225;
      4'd3:    v = 10'd35;
      4'd4:    v = 10'd325;
      4'd5:    v = 10'd685;
      4'd6:    v = 10'd0;
      4'd7:    v = 10'd305;
      4'd8:    v = 10'd665;
      4'd9:    v = 10'd395;
      4'd10:   v = 10'd585;
      4'd11:   v = 10'd415;
      4'd12:   v = 10'd495;
      default: v = '1;
    endcase
    return v;
  endfunction

  function automatic logic [BAND_W-1:0] band_hi(input logic [3:0] idx);
    logic [BAND_W-1:0] v;
    unique case (idx)
      4'd0:    v = 10'd225;
      4'd1:    v = 10'd135;
      4'd2:    v = 10'd325;
      4'd3:    v = 10'd55;
      4'd4:    v = 10'd305;   // empty band, never matches
      4'd5:    v = 10'd720;
      4'd6:    v = 10'd35;
      4'd7:    v = 10'd395;
      4'd8:    v = 10'd685;
      4'd9:    v = 10'd415;
      4'd10:   v = 10'd665;
      4'd11:   v = 10'd495;
      4'd12:   v = 10'd585;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic motion_t band_code(input logic [3:0] idx);
    motion_t v;
    unique case (idx)
      4'd0:    v = MOT_FWD;
      4'd1:    v = MOT_FWD_RIGHT;
      4'd2:    v = MOT_FWD_LEFT;
      4'd3:    v = MOT_FWD_PIVOT_R;
      4'd4:    v = MOT_FWD_PIVOT_L;
      4'd5:    v = MOT_SPIN_RIGHT;
      4'd6:    v = MOT_SPIN_RIGHT;
      4'd7:    v = MOT_SPIN_LEFT;
      4'd8:    v = MOT_REV_PIVOT_R;
      4'd9:    v = MOT_REV_PIVOT_L;
      4'd10:   v = MOT_REV_RIGHT;
      4'd11:   v = MOT_REV_LEFT;
      4'd12:   v = MOT_REV;
      default: v = MOT_SPIN_LEFT;
    endcase
    return v;
  endfunction

  // Per-wheel factors, -2..2
  function automatic logic signed [2:0] factor_left(input motion_t code);
    logic signed [2:0] f;
    unique case (code)
      MOT_SPIN_LEFT:   f = -3'sd1;
      MOT_FWD_PIVOT_R: f = 3'sd1;
      MOT_FWD_RIGHT:   f = 3'sd2;
      MOT_FWD:         f = 3'sd2;
      MOT_FWD_LEFT:    f = 3'sd1;
      MOT_FWD_PIVOT_L: f = 3'sd0;
      MOT_SPIN_RIGHT:  f = 3'sd1;
      MOT_REV_PIVOT_R: f = -3'sd1;
      MOT_REV_RIGHT:   f = -3'sd2;
      MOT_REV:         f = -3'sd2;
      MOT_REV_LEFT:    f = -3'sd1;
      MOT_REV_PIVOT_L: f = 3'sd0;
      default:         f = 3'sd0;
    endcase
    return f;
  endfunction

  function automatic logic signed [2:0] factor_right(input motion_t code);
    logic signed [2:0] f;
    unique case (code)
      MOT_SPIN_LEFT:   f = 3'sd1;
      MOT_FWD_PIVOT_R: f = 3'sd0;
      MOT_FWD_RIGHT:   f = 3'sd1;
      MOT_FWD:         f = 3'sd2;
      MOT_FWD_LEFT:    f = 3'sd2;
      MOT_FWD_PIVOT_L: f = 3'sd1;
      MOT_SPIN_RIGHT:  f = -3'sd1;
      MOT_REV_PIVOT_R: f = 3'sd0;
      MOT_REV_RIGHT:   f = -3'sd1;
      MOT_REV:         f = -3'sd2;
      MOT_REV_LEFT:    f = -3'sd2;
      MOT_REV_PIVOT_L: f = -3'sd1;
      default:         f = 3'sd0;
    endcase
    return f;
  endfunction

  // magnitude times factor: a shift and an optional negate
  function automatic logic signed [SPEED_W-1:0] wheel_speed(input logic [MAG_W-1:0] mag,
                                                            input logic signed [2:0] f);
    logic [SPEED_W-1:0] m6;
    logic [SPEED_W-1:0] v;
    m6 = {{(SPEED_W-MAG_W){1'b0}}, mag};
    unique case (f)
      3'sd1, -3'sd1: v = m6;
      3'sd2, -3'sd2: v = m6 << 1;
      default:       v = '0;
    endcase
    if (f[2]) begin
      v = -v;
    end
    return signed'(v);
  endfunction

endpackage

>>> rtl/jtw_cordic.sv
// Pipelined CORDIC vectoring unit: one rotation step per register stage.
module jtw_cordic #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [AXIS_WIDTH-1:0]         in_fwd_mag,
  input  logic [AXIS_WIDTH-1:0]         in_side_mag,
  input  jtw_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic signed [jtw_pkg::ZW-1:0] out_z,
  output jtw_pkg::side_t                out_side
);

  localparam int STEPS = jtw_pkg::CORDIC_STEPS;
  localparam int XW    = jtw_pkg::XW;
  localparam int ZW    = jtw_pkg::ZW;
  localparam int PRE   = jtw_pkg::CORDIC_SCALE - AXIS_WIDTH;

  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic signed [XW-1:0] x_r    [STEPS];
  logic signed [XW-1:0] y_r    [STEPS];
  logic signed [ZW-1:0] z_r    [STEPS];
  jtw_pkg::side_t       side_r [STEPS];
  logic [STEPS-1:0]     v_r;

  assign x0 = signed'({{(XW-AXIS_WIDTH){1'b0}}, in_side_mag} << PRE);
  assign y0 = signed'({{(XW-AXIS_WIDTH){1'b0}}, in_fwd_mag} << PRE);

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] xp;
    logic signed [XW-1:0] yp;
    logic signed [ZW-1:0] zp;
    jtw_pkg::side_t       sp;
    logic                 vp;
    logic                 y_pos;

    if (i == 0) begin : g_first
      assign xp = x0;
      assign yp = y0;
      assign zp = '0;
      assign sp = in_side;
      assign vp = in_valid;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign sp = side_r[i-1];
      assign vp = v_r[i-1];
    end

    assign y_pos = !yp[XW-1] && (yp != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= sp;
        if (y_pos) begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + jtw_pkg::atan_lut(5'(i));
        end else begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - jtw_pkg::atan_lut(5'(i));
        end
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_z     = z_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

>>> rtl/joystick_to_wheel_speeds_top.sv
// Top level of the joystick to wheel speeds mixer: magnitude, heading, sector lookup, stream ports.
//
// Differential-drive mixer. Each input transaction carries one joystick sample
// (forward and side axes, signed fractions of AXIS_WIDTH bits); each produces
// exactly one output transaction with left and right wheel speeds (units of
// 0.05, -28..28) and the motion code (0..11, code 5 never appears because its
// sector is empty). The heading comes from an 18-stage CORDIC vectoring
// pipeline, one rotation per stage, rounded to 1/2^ANGLE_FRAC_BITS degree; the
// magnitude in tenths comes from an exact squared-radius compare against 15
// thresholds. The datapath is fully pipelined: one transaction per clock
// whenever in_tready is high. Every stage moves together; a
// one-entry skid buffer behind the output register absorbs a stall so that
// in_tready is a plain register (low only while the skid entry is full).
// There is no configuration and no state between samples.
module joystick_to_wheel_speeds_top #(
  parameter int AXIS_WIDTH      = 16,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [AXIS_WIDTH-1:0] stick_fwd, [2*AXIS_WIDTH-1:AXIS_WIDTH] stick_side, rest zero
  input  logic [((2*AXIS_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [5:0] left_speed, [11:6] right_speed, [15:12] motion_code
  output logic [jtw_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  localparam int AW    = AXIS_WIDTH;
  localparam int AF    = ANGLE_FRAC_BITS;
  localparam int SQW   = 2 * AW;            // squared axis / sum of squares
  localparam int MW    = 2 * AW + 8;        // 400 * sum of squares
  localparam int HW    = AF + 9;            // heading, 0..360 deg
  localparam int ZW    = jtw_pkg::ZW;
  localparam int MAG_W = jtw_pkg::MAG_W;
  localparam int RND   = 2 ** (jtw_pkg::Z_FRAC - AF - 1);
  localparam logic [HW-1:0] H180 = HW'(180 * (2 ** AF));
  localparam logic [HW-1:0] H360 = HW'(360 * (2 ** AF));

  // Whole pipeline advances unless the skid entry holds a result.
  logic en;
  logic skid_valid_r;
  logic out_valid_r;
  assign en        = !skid_valid_r;
  assign in_tready = en;

  logic signed [AW-1:0] stick_fwd;
  logic signed [AW-1:0] stick_side;
  assign stick_fwd  = in_tdata[AW-1:0];
  assign stick_side = in_tdata[2*AW-1:AW];

  // ---------------- P1: sign split and absolute value ----------------
  logic          v1_r;
  logic [AW-1:0] afwd1_r, aside1_r;
  logic          fneg1_r, sneg1_r;

  // ---------------- P2: squares ----------------
  logic           v2_r;
  logic [SQW-1:0] sqf2_r, sqs2_r;
  logic [AW-1:0]  afwd2_r, aside2_r;
  logic           fneg2_r, sneg2_r;

  // ---------------- P3: sum of squares ----------------
  logic           v3_r;
  logic [SQW-1:0] sum3_r;
  logic [AW-1:0]  afwd3_r, aside3_r;
  logic           fneg3_r, sneg3_r;

  // ---------------- P4: times 400 ----------------
  logic          v4_r;
  logic [MW-1:0] scl4_r;
  logic [AW-1:0] afwd4_r, aside4_r;
  logic          fneg4_r, sneg4_r;

  // ---------------- P5: magnitude in tenths ----------------
  logic             v5_r;
  logic [MAG_W-1:0] mag5_r;
  logic [MAG_W-1:0] mag5_nxt;
  logic [AW-1:0]    afwd5_r, aside5_r;
  logic             fneg5_r, sneg5_r;
  jtw_pkg::side_t   side5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fneg1_r  <= stick_fwd[AW-1];
      sneg1_r  <= stick_side[AW-1];
      afwd1_r  <= stick_fwd[AW-1]  ? AW'(0) - AW'(stick_fwd)  : AW'(stick_fwd);
      aside1_r <= stick_side[AW-1] ? AW'(0) - AW'(stick_side) : AW'(stick_side);

      sqf2_r   <= SQW'(afwd1_r) * SQW'(afwd1_r);
      sqs2_r   <= SQW'(aside1_r) * SQW'(aside1_r);
      afwd2_r  <= afwd1_r;
      aside2_r <= aside1_r;
      fneg2_r  <= fneg1_r;
      sneg2_r  <= sneg1_r;

      sum3_r   <= sqf2_r + sqs2_r;   // at most 2^(2*AW-1), no carry out
      afwd3_r  <= afwd2_r;
      aside3_r <= aside2_r;
      fneg3_r  <= fneg2_r;
      sneg3_r  <= sneg2_r;

      scl4_r   <= (MW'(sum3_r) << 8) + (MW'(sum3_r) << 7) + (MW'(sum3_r) << 4);
      afwd4_r  <= afwd3_r;
      aside4_r <= aside3_r;
      fneg4_r  <= fneg3_r;
      sneg4_r  <= sneg3_r;

      mag5_r   <= mag5_nxt;
      afwd5_r  <= afwd4_r;
      aside5_r <= aside4_r;
      fneg5_r  <= fneg4_r;
      sneg5_r  <= sneg4_r;
    end
  end

  // round(10*r) >= k  <=>  400*r^2 >= (2k-1)^2, with r^2 scaled by 2^(2*AW-2)
  always_comb begin
    logic [MW-1:0] thr;
    mag5_nxt = '0;
    for (int k = 1; k <= 15; k++) begin
      thr = MW'((2 * k - 1) * (2 * k - 1)) << (2 * AW - 2);
      if (scl4_r >= thr) begin
        mag5_nxt = MAG_W'(k);
      end
    end
  end

  always_comb begin
    side5.mag       = mag5_r;
    side5.fwd_neg   = fneg5_r;
    side5.side_neg  = sneg5_r;
    side5.side_zero = (aside5_r == '0);
    side5.fwd_zero  = (afwd5_r == '0);
  end

  // ---------------- CORDIC: base angle atan2(|fwd|, |side|) ----------------
  logic                 vc;
  logic signed [ZW-1:0] zc;
  jtw_pkg::side_t       sc;

  jtw_cordic #(
    .AXIS_WIDTH (AW)
  ) u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v5_r),
    .in_fwd_mag  (afwd5_r),
    .in_side_mag (aside5_r),
    .in_side     (side5),
    .out_valid   (vc),
    .out_z       (zc),
    .out_side    (sc)
  );

  // ---------------- P6: clamp to [0, 90] deg and round ----------------
  logic           v6_r;
  logic [HW-1:0]  a6_r;
  logic [HW-1:0]  a6_nxt;
  jtw_pkg::side_t s6_r;

  always_comb begin
    logic [ZW-1:0] zcl;
    logic [ZW-1:0] zrn;
    if (zc[ZW-1]) begin
      zcl = '0;
    end else if (zc > ZW'(jtw_pkg::ZMAX)) begin
      zcl = ZW'(jtw_pkg::ZMAX);
    end else begin
      zcl = unsigned'(zc);
    end
    zrn = zcl + ZW'(RND);
    a6_nxt = sc.fwd_zero ? '0 : HW'(zrn >> (jtw_pkg::Z_FRAC - AF));
  end

  // ---------------- P7: quadrant fold to heading ----------------
  logic             v7_r;
  logic [HW-1:0]    h7_r;
  logic [HW-1:0]    h7_nxt;
  logic [MAG_W-1:0] mag7_r;

  always_comb begin
    priority if (!s6_r.fwd_neg && (s6_r.side_neg || s6_r.side_zero)) begin
      h7_nxt = a6_r;
    end else if (!s6_r.fwd_neg) begin
      h7_nxt = H180 - a6_r;
    end else if (!s6_r.side_neg) begin
      h7_nxt = H180 + a6_r;
    end else begin
      h7_nxt = H360 - a6_r;
    end
  end

  // ---------------- P8: sector lookup, first band in order wins ----------------
  logic             v8_r;
  jtw_pkg::motion_t code8_r;
  jtw_pkg::motion_t code8_nxt;
  logic             hit8_r;
  logic             hit8_nxt;
  logic [MAG_W-1:0] mag8_r;

  always_comb begin
    logic [HW-1:0] lo;
    logic [HW-1:0] hi;
    code8_nxt = jtw_pkg::MOT_SPIN_LEFT;
    hit8_nxt  = 1'b0;
    for (int b = jtw_pkg::NUM_BANDS - 1; b >= 0; b--) begin
      lo = HW'(jtw_pkg::band_lo(4'(b))) << (AF - 1);
      hi = HW'(jtw_pkg::band_hi(4'(b))) << (AF - 1);
      if (h7_r >= lo && h7_r <= hi) begin
        code8_nxt = jtw_pkg::band_code(4'(b));
        hit8_nxt  = 1'b1;
      end
    end
  end

  // ---------------- P9: wheel speeds ----------------
  logic                            v9_r;
  logic [jtw_pkg::OUT_TDATA_W-1:0] d9_r;
  logic [jtw_pkg::OUT_TDATA_W-1:0] d9_nxt;

  always_comb begin
    logic signed [jtw_pkg::SPEED_W-1:0] sl;
    logic signed [jtw_pkg::SPEED_W-1:0] sr;
    sl = jtw_pkg::wheel_speed(mag8_r, jtw_pkg::factor_left(code8_r));
    sr = jtw_pkg::wheel_speed(mag8_r, jtw_pkg::factor_right(code8_r));
    if (hit8_r) begin
      d9_nxt = {code8_r, sr, sl};
    end else begin
      d9_nxt = '0;   // no sector matched
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v6_r <= vc;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a6_r    <= a6_nxt;
      s6_r    <= sc;
      h7_r    <= h7_nxt;
      mag7_r  <= s6_r.mag;
      code8_r <= code8_nxt;
      hit8_r  <= hit8_nxt;
      mag8_r  <= mag7_r;
      d9_r    <= d9_nxt;
    end
  end

  // ---------------- output register and skid entry ----------------
  logic [jtw_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [jtw_pkg::OUT_TDATA_W-1:0] skid_data_r;
  logic                            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;   // skid moves to output, output stays valid
      end
    end else if (v9_r) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (v9_r) begin
      if (out_free) begin
        out_data_r <= d9_r;
      end else begin
        skid_data_r <= d9_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
